### rtl/core/waveform_intensity_histogram_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the intensity histogram
// Shorthand for concurrent checks clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef WAVEFORM_INTENSITY_HISTOGRAM_ASSERT_SVH
`define WAVEFORM_INTENSITY_HISTOGRAM_ASSERT_SVH

// Condition holds at every edge out of reset.
`define WIH_ASSERT_HOLDS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("histogram check failed");

// Consequent holds in the same cycle as the antecedent.
`define WIH_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("histogram check failed");

// Consequent holds in the cycle after the antecedent.
`define WIH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("histogram check failed");

`endif

### rtl/core/wih_pkg.sv
// ----------------------------------------------------------------------------
// wih_pkg
// Shared types and constants of the intensity histogram.
// ----------------------------------------------------------------------------
package wih_pkg;

  localparam int LEVELS     = 256;
  localparam int LEVEL_W    = 8;
  localparam int COL_W_MAX  = 12;   // columns up to 4096
  localparam int OFF_W      = 12;   // offset within a slice, slices up to 4096
  localparam int COUNT_W    = 16;
  localparam int Q_DEPTH    = 4;

  localparam logic [23:0] X_SCALE_RST = 24'd65536;
  localparam logic [15:0] RED_RST     = 16'd2550;
  localparam logic [15:0] GREEN_RST   = 16'd1780;
  localparam logic [15:0] BLUE_RST    = 16'd250;

  typedef enum logic [1:0] {
    CMD_ACCUM      = 2'd0,
    CMD_READ       = 2'd1,
    CMD_READ_CLEAR = 2'd2,
    CMD_NONE       = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_X_SCALE = 2'd0,
    REG_RED     = 2'd1,
    REG_GREEN   = 2'd2,
    REG_BLUE    = 2'd3
  } reg_idx_t;

  // Classified request handed from the front to the back.
  typedef enum logic [2:0] {
    K_ACCUM      = 3'd0,
    K_READ       = 3'd1,
    K_READ_CLEAR = 3'd2,
    K_DROP       = 3'd3,
    K_NULL       = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [COL_W_MAX-1:0] col;
    logic [LEVEL_W-1:0]   lvl;
  } q_entry_t;

  typedef struct packed {
    logic [23:0] x_scale;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } cfg_t;

endpackage

### rtl/core/wih_queue.sv
// ----------------------------------------------------------------------------
// wih_queue
// Small request queue between the classify front and the bin back end.
// ----------------------------------------------------------------------------
module wih_queue
  import wih_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t push_data,
  output logic     full,
  input  logic     pop,
  output logic     valid,
  output q_entry_t pop_data
);

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  q_entry_t         slots [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(Q_DEPTH));
  assign valid    = (count != '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

### rtl/core/wih_front.sv
// ----------------------------------------------------------------------------
// wih_front
// Accept requests, compute the screen column and classify into the queue.
// ----------------------------------------------------------------------------
module wih_front
  import wih_pkg::*;
#(
  parameter int COLUMNS     = 1024,
  parameter int SLICE_LEN   = 256,
  parameter int SCALE_SHIFT = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [23:0] x_scale,
  input  logic        hold,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        q_full,
  output logic        q_push,
  output q_entry_t    q_data
);

  localparam int RECIP_W = 31;
  // ceil(2^32 / SLICE_LEN): exact slice index for any 16-bit position
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << 32) + 64'(SLICE_LEN) - 64'd1) / 64'(SLICE_LEN));

  typedef struct packed {
    cmd_t        cmd;
    logic [7:0]  smp;
    logic [15:0] idx;
    logic [9:0]  rcol;
    logic [7:0]  rlev;
  } item_t;

  logic        adv;
  logic        v1, v2, v3, v4;
  item_t       it1, it2, it3, it4;
  logic [15:0] q2;
  logic [15:0] base3;
  logic [OFF_W-1:0] off3;
  logic [39:0] pb4;
  logic [35:0] po4;

  logic [46:0] qprod;
  logic [28:0] bprod;
  logic [40:0] col_sum;
  logic        col_ok;
  logic        rd_ok;

  // Whole pipe advances together while the queue has room.
  assign adv      = !q_full;
  assign s_tready = adv && !hold;

  assign qprod = {31'd0, it1.idx} * {16'd0, RECIP};
  assign bprod = {13'd0, q2} * 29'(SLICE_LEN);

  assign col_sum = {1'b0, (pb4 >> SCALE_SHIFT)} + {5'd0, (po4 >> SCALE_SHIFT)};
  assign col_ok  = col_sum < 41'(COLUMNS);
  assign rd_ok   = {3'd0, it4.rcol} < 13'(COLUMNS);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= s_tvalid && !hold;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it1.cmd  <= cmd_t'(s_tuser);
      it1.smp  <= s_tdata[7:0];
      it1.idx  <= s_tdata[23:8];
      it1.rcol <= s_tdata[33:24];
      it1.rlev <= s_tdata[41:34];
      it2      <= it1;
      q2       <= {1'b0, qprod[46:32]};
      it3      <= it2;
      base3    <= bprod[15:0];
      off3     <= OFF_W'(it2.idx - bprod[15:0]);
      it4      <= it3;
      pb4      <= {24'd0, base3} * {16'd0, x_scale};
      po4      <= {24'd0, off3} * {12'd0, x_scale};
    end
  end

  assign q_push = v4 && adv;

  always_comb begin
    q_data.kind = K_NULL;
    q_data.col  = '0;
    q_data.lvl  = '0;
    case (it4.cmd)
      CMD_ACCUM: begin
        q_data.col = col_sum[COL_W_MAX-1:0];
        q_data.lvl = it4.smp;
        if (it4.smp == 8'h00 || it4.smp == 8'hff || !col_ok) begin
          q_data.kind = K_DROP;
        end else begin
          q_data.kind = K_ACCUM;
        end
      end
      CMD_READ, CMD_READ_CLEAR: begin
        q_data.col = {2'd0, it4.rcol};
        q_data.lvl = it4.rlev;
        if (rd_ok) begin
          q_data.kind = (it4.cmd == CMD_READ) ? K_READ : K_READ_CLEAR;
        end
      end
      default: begin
        q_data.kind = K_NULL;
      end
    endcase
  end

endmodule

### rtl/core/wih_back.sv
// ----------------------------------------------------------------------------
// wih_back
// Hit store, read-modify-write of one bin, colour and output register.
// ----------------------------------------------------------------------------
module wih_back
  import wih_pkg::*;
#(
  parameter int COLUMNS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        q_valid,
  output logic        q_pop,
  input  q_entry_t    q_data,
  output logic        clearing,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,
  output logic [0:0]  m_tuser
);

  localparam int DEPTH  = COLUMNS * LEVELS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int COL_W  = ADDR_W - LEVEL_W;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_READ   = 5'b00010,
    ST_UPDATE = 5'b00100,
    ST_COLOUR = 5'b01000,
    ST_OUT    = 5'b10000
  } state_t;

  function automatic logic [7:0] chan_clamp(input logic [31:0] prod);
    logic [7:0] res;
    res = (prod[31:16] != 16'd0) ? 8'hff : prod[15:8];
    return res;
  endfunction

  logic [COUNT_W-1:0] mem [DEPTH];
  logic [COUNT_W-1:0] rdata;

  state_t             state;
  logic               busy;
  logic [ADDR_W-1:0]  clr_addr;
  q_entry_t           cur;
  logic [COUNT_W-1:0] cnt;
  logic [31:0]        pr, pg, pbl;

  logic [ADDR_W-1:0]  cur_addr;
  logic [COUNT_W-1:0] inc;
  logic               we;
  logic [ADDR_W-1:0]  waddr;
  logic [COUNT_W-1:0] wdata;
  logic               out_load;
  logic [31:0]        pixel;

  assign clearing = busy;
  assign cur_addr = {cur.col[COL_W-1:0], cur.lvl};
  assign inc      = (rdata == 16'hffff) ? rdata : rdata + 16'd1;
  assign q_pop    = (state == ST_IDLE) && q_valid && !busy;
  assign out_load = (state == ST_OUT) && (!m_tvalid || m_tready);

  always_comb begin
    we    = 1'b0;
    waddr = cur_addr;
    wdata = '0;
    if (busy) begin
      we    = 1'b1;
      waddr = clr_addr;
    end else if (state == ST_UPDATE) begin
      if (cur.kind == K_ACCUM) begin
        we    = 1'b1;
        wdata = inc;
      end else if (cur.kind == K_READ_CLEAR) begin
        we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[cur_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + ADDR_W'(1);
      if (clr_addr == ADDR_W'(DEPTH - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_pop) begin
            if (q_data.kind == K_ACCUM || q_data.kind == K_READ ||
                q_data.kind == K_READ_CLEAR) begin
              state <= ST_READ;
            end else begin
              state <= ST_COLOUR;
            end
          end
        end
        ST_READ:   state <= ST_UPDATE;
        ST_UPDATE: state <= ST_COLOUR;
        ST_COLOUR: state <= ST_OUT;
        ST_OUT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign pixel = (cnt == '0) ? 32'h0000_0000 :
                 {8'hff, chan_clamp(pbl), chan_clamp(pg), chan_clamp(pr)};

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
      cnt <= '0;
    end
    if (state == ST_UPDATE) begin
      cnt <= (cur.kind == K_ACCUM) ? inc : rdata;
    end
    if (state == ST_COLOUR) begin
      pr  <= {16'd0, cfg.red}   * {16'd0, cnt};
      pg  <= {16'd0, cfg.green} * {16'd0, cnt};
      pbl <= {16'd0, cfg.blue}  * {16'd0, cnt};
    end
    if (out_load) begin
      m_tdata <= {cnt, pixel};
      m_tuser <= (cur.kind == K_DROP);
    end
  end

endmodule

### rtl/core/waveform_intensity_histogram.sv
// ----------------------------------------------------------------------------
// waveform_intensity_histogram
// Persistence histogram: bins ADC samples by (column, level) and reads back
// hit counts with their display colour.
// ----------------------------------------------------------------------------
//
//  Channel  Side    Moves                            Payload
//  -------  ------  -------------------------------  --------------------------
//  s_*      input   one request per accept           tuser command, tdata fields
//  m_*      output  one result per request, in order tdata count/pixel, tuser drop
//  APB      config  one register per write           x_scale and colour gains
//
//  Order: the column pipeline, then per request the bin sequencer steps (pop, read,
//  update, colour, output); dropped and null requests skip read and update. The
//  back pops no new request until the last one has left through the output step.
//  Reset: the hit store is swept to zero, one bin a cycle, over all COLUMNS*256
//  bins (262144 at the default size); s_tready stays low until it ends.
//  Stalls: a stalled output holds the back, fills the four-entry queue, drops s_tready.
// ----------------------------------------------------------------------------
module waveform_intensity_histogram
  import wih_pkg::*;
#(
  parameter int COLUMNS     = 1024,
  parameter int SLICE_LEN   = 256,
  parameter int SCALE_SHIFT = 16
) (
  input  logic        clk,
  input  logic        rst,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // sample[7:0], sample_index[23:8],
                                 // column[33:24], level[41:34], zero[47:42]
  input  logic [1:0]  s_tuser,   // command[1:0]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // pixel[31:0], hit_count[47:32]
  output logic [0:0]  m_tuser,   // dropped[0]
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t     cfg;
  logic     cfg_we;
  reg_idx_t reg_sel;

  logic     q_full;
  logic     q_push;
  q_entry_t q_in;
  logic     q_valid;
  logic     q_pop;
  q_entry_t q_out;
  logic     clearing;

  // Configuration registers: write on the access phase, no wait states.
  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[3:2]);
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_scale <= X_SCALE_RST;
      cfg.red     <= RED_RST;
      cfg.green   <= GREEN_RST;
      cfg.blue    <= BLUE_RST;
    end else if (cfg_we) begin
      case (reg_sel)
        REG_X_SCALE: cfg.x_scale <= pwdata[23:0];
        REG_RED:     cfg.red     <= pwdata[15:0];
        REG_GREEN:   cfg.green   <= pwdata[15:0];
        REG_BLUE:    cfg.blue    <= pwdata[15:0];
        default:     cfg         <= cfg;
      endcase
    end
  end

  // Readback mux.
  always_comb begin
    case (reg_sel)
      REG_X_SCALE: prdata = {8'd0, cfg.x_scale};
      REG_RED:     prdata = {16'd0, cfg.red};
      REG_GREEN:   prdata = {16'd0, cfg.green};
      REG_BLUE:    prdata = {16'd0, cfg.blue};
      default:     prdata = 32'd0;
    endcase
  end

  // Front: accept, compute the column and classify each request.
  wih_front #(
    .COLUMNS     (COLUMNS),
    .SLICE_LEN   (SLICE_LEN),
    .SCALE_SHIFT (SCALE_SHIFT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .x_scale  (cfg.x_scale),
    .hold     (clearing),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  // Decoupling queue: lets the front keep taking requests while the back
  // works on one bin.
  wih_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_out)
  );

  // Back: hit store update, colour and the output register.
  wih_back #(
    .COLUMNS (COLUMNS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_data   (q_out),
    .clearing (clearing),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

### rtl/core/wih_checker.sv
// ----------------------------------------------------------------------------
// wih_checker
// Port-level checks of the histogram, bound to the top level.
// ----------------------------------------------------------------------------
`include "waveform_intensity_histogram_assert.svh"

module wih_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic [0:0]  m_tuser
);

  logic [4:0] pending;
  logic       s_acc;
  logic       m_acc;

  assign s_acc = s_tvalid && s_tready;
  assign m_acc = m_tvalid && m_tready;

  // Requests taken but not yet answered.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (s_acc && !m_acc) begin
      pending <= pending + 5'd1;
    end else if (m_acc && !s_acc) begin
      pending <= pending - 5'd1;
    end
  end

  // The store sweep keeps requests out right after reset.
  `WIH_ASSERT_IMPLIES(a_no_accept_after_reset, $past(rst), !s_tready)
  // No result without a request behind it.
  `WIH_ASSERT_IMPLIES(a_result_has_request, m_tvalid, pending != 5'd0)
  // A dropped sample carries no count and no colour.
  `WIH_ASSERT_IMPLIES(a_drop_is_empty, m_tvalid && m_tuser[0], m_tdata == 48'd0)
  // An empty bin is black.
  `WIH_ASSERT_IMPLIES(a_empty_bin_black, m_tvalid && m_tdata[47:32] == 16'd0,
                      m_tdata[31:0] == 32'd0)
  // A stalled result holds.
  `WIH_ASSERT_NEXT(a_result_holds, m_tvalid && !m_tready,
                   m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind waveform_intensity_histogram wih_checker u_wih_checker (.*);

### test/histogram_checker.sv
// ----------------------------------------------------------------------------
// histogram_checker
// Watches the request, result and register channels of the intensity
// histogram, keeps a shadow of its bins and gains, and compares every result
// field by field against the predicted value.
// ----------------------------------------------------------------------------
module histogram_checker
  import wih_pkg::*;
#(
  parameter int COLUMNS     = 1024,
  parameter int SLICE_LEN   = 256,
  parameter int SCALE_SHIFT = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,   // sample, sample_index, column, level, zero
  input  logic [1:0]  s_tuser,   // command
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,   // pixel, hit_count
  input  logic [0:0]  m_tuser,   // dropped
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output int          mismatches,
  output int          pending
);

  typedef struct packed {
    logic [31:0] pixel;
    logic [15:0] hit_count;
    logic        dropped;
  } bin_result_t;

  bin_result_t expected_results[$];
  logic [15:0] bin_counts [COLUMNS*LEVELS];
  cfg_t        shadow_cfg;
  bit          store_cleared;

  initial begin
    mismatches    = 0;
    pending       = 0;
    store_cleared = 1'b0;
  end

  function automatic logic [7:0] channel_level(logic [15:0] gain, logic [15:0] hits);
    logic [31:0] product;
    product = 32'(gain) * 32'(hits);
    return (product[31:8] > 24'd255) ? 8'hff : product[15:8];
  endfunction

  function automatic logic [31:0] shade(logic [15:0] hits);
    if (hits == '0) return '0;
    return {8'hff, channel_level(shadow_cfg.blue, hits),
            channel_level(shadow_cfg.green, hits), channel_level(shadow_cfg.red, hits)};
  endfunction

  // Apply one request to the shadow bins and return the result it yields.
  function automatic bin_result_t bin_access(cmd_t cmd, logic [7:0] sample,
                                             logic [15:0] index, logic [9:0] column,
                                             logic [7:0] level);
    bin_result_t res;
    logic [63:0] offset;
    logic [63:0] base;
    logic [63:0] col;
    int          addr;
    res = '0;
    case (cmd)
      CMD_ACCUM: begin
        offset = 64'(index) % SLICE_LEN;
        base   = 64'(index) - offset;
        col    = ((base * 64'(shadow_cfg.x_scale)) >> SCALE_SHIFT)
               + ((offset * 64'(shadow_cfg.x_scale)) >> SCALE_SHIFT);
        if (sample == 8'h00 || sample == 8'hff || col >= 64'(COLUMNS)) begin
          res.dropped = 1'b1;
        end else begin
          addr = int'(col) * LEVELS + int'(sample);
          if (bin_counts[addr] != 16'hffff) bin_counts[addr] = bin_counts[addr] + 16'd1;
          res.hit_count = bin_counts[addr];
          res.pixel     = shade(bin_counts[addr]);
        end
      end
      CMD_READ, CMD_READ_CLEAR: begin
        if (32'(column) < COLUMNS) begin
          addr          = int'(column) * LEVELS + int'(level);
          res.hit_count = bin_counts[addr];
          res.pixel     = shade(bin_counts[addr]);
          if (cmd == CMD_READ_CLEAR) bin_counts[addr] = '0;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    bin_result_t want;
    if (rst) begin
      expected_results.delete();
      shadow_cfg = {X_SCALE_RST, RED_RST, GREEN_RST, BLUE_RST};
      if (!store_cleared) begin
        foreach (bin_counts[i]) bin_counts[i] = '0;
        store_cleared = 1'b1;
      end
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_X_SCALE: shadow_cfg.x_scale = pwdata[23:0];
          REG_RED:     shadow_cfg.red     = pwdata[15:0];
          REG_GREEN:   shadow_cfg.green   = pwdata[15:0];
          REG_BLUE:    shadow_cfg.blue    = pwdata[15:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        expected_results.push_back(bin_access(cmd_t'(s_tuser), s_tdata[7:0], s_tdata[23:8],
                                              s_tdata[33:24], s_tdata[41:34]));
      end
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding: tdata %h tuser %b", m_tdata, m_tuser);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (m_tdata[31:0] !== want.pixel) begin
            $error("pixel: expected %h, actual %h", want.pixel, m_tdata[31:0]);
            mismatches++;
          end
          if (m_tdata[47:32] !== want.hit_count) begin
            $error("hit_count: expected %0d, actual %0d", want.hit_count, m_tdata[47:32]);
            mismatches++;
          end
          if (m_tuser[0] !== want.dropped) begin
            $error("dropped: expected %b, actual %b", want.dropped, m_tuser[0]);
            mismatches++;
          end
        end
      end
    end
    pending <= expected_results.size();
  end

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives requests and register writes into the intensity histogram, stalls
// the result side at random, and reports the verdict from the checker's
// mismatch count.
// ----------------------------------------------------------------------------
module tb_top;
  import wih_pkg::*;

  localparam int COLUMNS     = 1024;
  localparam int SLICE_LEN   = 256;
  localparam int SCALE_SHIFT = 16;

  // Requests per random phase, four phases in all.
  localparam int PHASE_REQUESTS = 375;
  // Back-to-back accumulates into one bin.
  localparam int HAMMER_HITS    = 40;
  // Cycles the result side holds off when asked for a long stall.
  localparam int LONG_HOLD      = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // sample[7:0], sample_index[23:8],
                               // column[33:24], level[41:34], zero[47:42]
  logic [1:0]  s_tuser = '0;   // command[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;        // pixel[31:0], hit_count[47:32]
  logic [0:0]  m_tuser;        // dropped[0]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int          mismatches;
  int          pending;

  // Each increment asks the result side for one long stall.
  int          hold_requests = 0;
  // Keeps the result side always ready while set.
  bit          results_hurry = 1'b0;
  // No gaps between requests while set.
  bit          steady_sender = 1'b0;

  always #10 clk = ~clk;

  waveform_intensity_histogram #(
    .COLUMNS    (COLUMNS),
    .SLICE_LEN  (SLICE_LEN),
    .SCALE_SHIFT(SCALE_SHIFT)
  ) u_top (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  histogram_checker #(
    .COLUMNS    (COLUMNS),
    .SLICE_LEN  (SLICE_LEN),
    .SCALE_SHIFT(SCALE_SHIFT)
  ) u_checker (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .mismatches, .pending
  );

  // Mostly no gap or a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Offer one request after an optional gap and hold it until accepted.
  // Leave tvalid high on return so back-to-back requests never drop it.
  task automatic send_request(cmd_t cmd, logic [7:0] sample, logic [15:0] index,
                              logic [9:0] column, logic [7:0] level);
    int gap;
    gap = steady_sender ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {6'b0, level, column, index, sample};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Drop tvalid and wait until every outstanding request has its result.
  // The first edge lets the checker count the last accepted request.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Two-phase register write: setup, then access until pready.
  task automatic write_register(reg_idx_t which, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {which, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_settings(logic [23:0] x_scale, logic [15:0] red,
                               logic [15:0] green, logic [15:0] blue);
    write_register(REG_X_SCALE, 32'(x_scale));
    write_register(REG_RED,     32'(red));
    write_register(REG_GREEN,   32'(green));
    write_register(REG_BLUE,    32'(blue));
  endtask

  // One random request. Accumulates and reads crowd into a small hot window
  // of columns 0..31 and levels 1..8 so that reads find bins with hits;
  // the rest spreads over the full field ranges, clipped levels included.
  task automatic send_random_request();
    int          r;
    cmd_t        cmd;
    logic [7:0]  sample;
    logic [15:0] index;
    logic [9:0]  column;
    logic [7:0]  level;
    r      = $urandom_range(0, 99);
    cmd    = (r < 60) ? CMD_ACCUM : (r < 77) ? CMD_READ :
             (r < 94) ? CMD_READ_CLEAR : CMD_NONE;
    sample = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(1, 8)) : 8'($urandom);
    r      = $urandom_range(0, 9);
    index  = (r < 7) ? 16'($urandom_range(0, 31)) :
             (r < 9) ? 16'($urandom_range(0, 1100)) : 16'($urandom);
    if (cmd == CMD_ACCUM) begin
      column = 10'($urandom);
      level  = 8'($urandom);
    end else begin
      column = ($urandom_range(0, 3) != 0) ? 10'($urandom_range(0, 31)) : 10'($urandom);
      level  = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(1, 8)) : 8'($urandom);
    end
    send_request(cmd, sample, index, column, level);
  endtask

  // Run one phase of random requests under the given settings.
  task automatic random_phase(logic [23:0] x_scale, logic [15:0] red,
                              logic [15:0] green, logic [15:0] blue, bit long_stall);
    drain_results();
    load_settings(x_scale, red, green, blue);
    if (long_stall) hold_requests <= hold_requests + 1;
    repeat (PHASE_REQUESTS) begin
      if ($urandom_range(0, 59) == 0) steady_sender = !steady_sender;
      send_random_request();
    end
  endtask

  // Result side: random stalls, stretches of steady readiness, and a long
  // hold-off whenever the stimulus asks for one.
  initial begin
    int hold;
    int seen;
    int gap;
    bit steady;
    hold   = 0;
    seen   = 0;
    steady = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (seen != hold_requests) begin
        seen = hold_requests;
        hold = LONG_HOLD;
      end
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else begin
        gap = (steady || results_hurry) ? 0 : pick_gap();
        if (gap == 0) begin
          m_tready <= 1'b1;
        end else begin
          m_tready <= 1'b0;
          hold = gap - 1;
        end
      end
      if ($urandom_range(0, 199) == 0) steady = !steady;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed requests under the reset settings: one column per sample.
    // The first one waits out the clearing sweep of the bins.
    send_request(CMD_ACCUM, 8'd1, 16'd0, '0, '0);               // lowest live level
    send_request(CMD_ACCUM, 8'd254, 16'd1023, 10'h3ff, 8'hff);  // last column, top level
    send_request(CMD_ACCUM, 8'd0, 16'd5, '0, '0);               // clipped low
    send_request(CMD_ACCUM, 8'd255, 16'd5, '0, '0);             // clipped high
    send_request(CMD_ACCUM, 8'd100, 16'd1024, '0, '0);          // just off-screen
    send_request(CMD_ACCUM, 8'd100, 16'hffff, '0, '0);          // far off-screen
    send_request(CMD_ACCUM, 8'd128, 16'd255, '0, '0);           // end of a slice
    send_request(CMD_ACCUM, 8'd128, 16'd256, '0, '0);           // start of the next
    send_request(CMD_ACCUM, 8'd1, 16'd0, '0, '0);               // second hit
    send_request(CMD_READ, '0, '0, 10'd0, 8'd1);
    send_request(CMD_READ, '0, '0, 10'd1023, 8'd254);
    send_request(CMD_READ_CLEAR, '0, '0, 10'd0, 8'd1);
    send_request(CMD_READ, '0, '0, 10'd0, 8'd1);                // emptied bin
    send_request(CMD_READ_CLEAR, '0, '0, 10'd1023, 8'd255);     // never hit
    send_request(CMD_READ, '0, '0, 10'd255, 8'd128);
    send_request(CMD_READ, '0, '0, 10'd256, 8'd0);
    send_request(CMD_NONE, 8'hff, 16'hffff, 10'h3ff, 8'hff);    // unused command
    drain_results();

    // Hammer one bin back to back, then read it back and clear it.
    results_hurry <= 1'b1;
    steady_sender = 1'b1;
    repeat (HAMMER_HITS) send_request(CMD_ACCUM, 8'd77, 16'd7, '0, '0);
    send_request(CMD_READ, '0, '0, 10'd7, 8'd77);
    send_request(CMD_READ_CLEAR, '0, '0, 10'd7, 8'd77);
    send_request(CMD_READ, '0, '0, 10'd7, 8'd77);
    steady_sender = 1'b0;
    results_hurry <= 1'b0;

    // Random phases, each under new settings; the extremes come in the
    // middle: every sample in column 0 with full gains, then the widest
    // scale with all gains zero.
    random_phase(24'd65536, 16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
    random_phase(24'd0, 16'hffff, 16'hffff, 16'hffff, 1'b0);
    random_phase(24'hffffff, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    random_phase(24'($urandom_range(1, 262143)), 16'($urandom_range(0, 600)),
                 16'($urandom_range(0, 600)), 16'($urandom_range(0, 600)), 1'b1);

    drain_results();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("** waveform_intensity_histogram: PASSED **");
    end else begin
      $display("** waveform_intensity_histogram: FAILED **");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run, clearing sweep included.
  initial begin
    #80_000_000;
    $display("** waveform_intensity_histogram: FAILED **");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/wih_pkg.sv
rtl/core/wih_queue.sv
rtl/core/wih_front.sv
rtl/core/wih_back.sv
rtl/core/waveform_intensity_histogram.sv
rtl/core/wih_checker.sv
test/histogram_checker.sv
test/tb_top.sv
